// ----- src/sbnt_pkg.sv -----
// Shared types, codes and constants for the sorted branch node table.
`default_nettype none
package sbnt_pkg;

    localparam int CAPACITY_DEF  = 32;
    localparam int KEY_WIDTH_DEF = 32;
    localparam logic [5:0] CAP_RESET = 6'd32;

    localparam logic [2:0] KIND_INSERT  = 3'd0;
    localparam logic [2:0] KIND_KSEARCH = 3'd1;
    localparam logic [2:0] KIND_ASEARCH = 3'd2;
    localparam logic [2:0] KIND_UPDATE  = 3'd3;
    localparam logic [2:0] KIND_SPLIT   = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_TOOFEW   = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key_value;
        logic [31:0] child_addr;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_key;
        logic [31:0] out_addr;
        logic [5:0]  out_index;
        logic [5:0]  entry_count;
        logic        first_changed;
        logic        last;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_INS_SCAN, S_INS_CHK, S_INS_SHIFT, S_INS_SHWR,
        S_INS_WRITE, S_KS_CHK0, S_KS_LOOP, S_KS_CMP, S_KS_CMP2, S_KS_FETCH,
        S_KS_GOT, S_AS_SCAN, S_AS_CHK, S_SP_RD, S_SP_GOT, S_SP_EMIT, S_EMIT
    } t_state;

    typedef enum logic [2:0] {RD_IDX, RD_IDXM1, RD_MID, RD_MIDP1, RD_POS, RD_ZERO} t_rd_src;
    typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_COUNT, IDX_HALF, IDX_INC, IDX_DEC} t_idx_op;
    typedef enum logic [1:0] {POS_HOLD, POS_IDX, POS_MID, POS_ZERO} t_pos_op;
    typedef enum logic [1:0] {BS_HOLD, BS_INIT, BS_LO, BS_HI} t_bs_op;
    typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_NEW, WR_UPD} t_wr_op;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_HALF} t_cnt_op;
    typedef enum logic [1:0] {RES_HOLD, RES_NEW, RES_RD, RES_UPD} t_res_op;

    typedef struct packed {
        logic       load_in;
        t_rd_src    rd_src;
        t_idx_op    idx_op;
        t_pos_op    pos_op;
        t_bs_op     bs_op;
        logic       mid_load;
        t_wr_op     wr_op;
        t_cnt_op    cnt_op;
        t_res_op    res_op;
        logic       stat_load;
        logic [2:0] stat;
        logic       out_load;
        logic       out_last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       full;
        logic       empty;
        logic       too_few;
        logic       idx_eq_count;
        logic       idx_eq_pos;
        logic       key_gt;
        logic       key_lt;
        logic       addr_eq;
        logic       bs_done;
        logic       mid_is_last;
        logic       split_last;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

// ----- src/sorted_branch_node_table_top.sv -----
// Top level of the sorted branch node table.
// Holds one B+tree branch node as (key, child address) entries sorted by key.
// Input channel: i_in_valid / o_in_stall carry one operation beat (insert,
// key search, address search, key update, split). Output channel:
// o_out_valid / i_out_stall carry result beats; last marks the final beat
// of a run. Config channel: i_cfg_valid / o_cfg_ready write capacity_limit.
// One operation is in flight at a time. Insert scans for the position and
// then shifts the later entries up, with scan and shift going through the
// single read port; key search is a binary search, address search a linear
// scan, and split emits one beat per entry in the upper half of the node.
// The next beat can be accepted in the cycle after the last result loads.
// The output register holds a finished beat while the receiver stalls;
// the controller waits before loading the next one.
// Reset empties the node and sets capacity_limit to 32; entry memories are
// not cleared, only entries below the count are ever used.
`default_nettype none
module sorted_branch_node_table_top #(
    parameter int CAPACITY  = sbnt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = sbnt_pkg::KEY_WIDTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_stall,
    input  wire sbnt_pkg::t_in  i_in_beat,
    output      logic           o_out_valid,
    input  wire logic           i_out_stall,
    output      sbnt_pkg::t_out o_out_beat,
    input  wire logic           i_cfg_valid,
    output      logic           o_cfg_ready,
    input  wire logic [5:0]     i_cfg_data
);
    sbnt_pkg::t_cmd cmd;
    sbnt_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    sbnt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_sts(sts), .o_cmd(cmd)
    );

    sbnt_datapath #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_beat(i_in_beat),
        .i_cfg_we(i_cfg_valid && o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_out_stall(i_out_stall), .i_cmd(cmd), .o_sts(sts),
        .o_out_valid(o_out_valid), .o_out_beat(o_out_beat)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted beat did not make the block busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (7'(o_out_beat.entry_count) <= 7'(CAPACITY)))
        else $error("entry count above capacity");

    a_fail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.status != sbnt_pkg::ST_OK) |-> o_out_beat.last)
        else $error("failed result not marked last");
endmodule
`default_nettype wire

// ----- src/sbnt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sbnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- src/sbnt_datapath.sv -----
// Datapath: entry memories, index and search registers, result register.
`default_nettype none
module sbnt_datapath #(
    parameter int CAPACITY  = sbnt_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = sbnt_pkg::KEY_WIDTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire sbnt_pkg::t_in   i_in_beat,
    input  wire logic            i_cfg_we,
    input  wire logic [5:0]      i_cfg_data,
    input  wire logic            i_out_stall,
    input  wire sbnt_pkg::t_cmd  i_cmd,
    output      sbnt_pkg::t_sts  o_sts,
    output      logic            o_out_valid,
    output      sbnt_pkg::t_out  o_out_beat
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int SW = CW + 1;

    logic [2:0]           r_kind;
    logic [KEY_WIDTH-1:0] r_key;
    logic [31:0]          r_addr;
    logic [5:0]           r_cap;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_end;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_pos, n_pos;
    logic [CW-1:0]        r_mid;
    logic signed [SW-1:0] r_first, r_last;
    logic [KEY_WIDTH-1:0] r_res_key;
    logic [31:0]          r_res_addr;
    logic                 r_res_chg;
    logic [2:0]           r_status;
    logic                 r_out_valid;
    sbnt_pkg::t_out       r_out;

    logic [KEY_WIDTH-1:0] rkey;
    logic [31:0]          raddr;
    logic [CW-1:0]        rd_idx, wr_idx, mid_c;
    logic signed [SW:0]   mid_sum;
    logic [7:0]           lim;
    logic                 key_we, addr_we;
    logic [KEY_WIDTH-1:0] key_wdata;
    logic [31:0]          addr_wdata;
    logic                 out_free;

    assign mid_sum = {r_first[SW-1], r_first} + {r_last[SW-1], r_last} + (SW+1)'(1);
    assign mid_c   = CW'(mid_sum >>> 1);
    assign lim     = (8'(r_cap) > 8'(CAPACITY)) ? 8'(CAPACITY) : 8'(r_cap);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        case (i_cmd.rd_src)
            sbnt_pkg::RD_IDX:   rd_idx = r_idx;
            sbnt_pkg::RD_IDXM1: rd_idx = r_idx - CW'(1);
            sbnt_pkg::RD_MID:   rd_idx = mid_c;
            sbnt_pkg::RD_MIDP1: rd_idx = r_mid + CW'(1);
            sbnt_pkg::RD_POS:   rd_idx = r_pos;
            default:            rd_idx = '0;
        endcase
    end

    always_comb begin
        key_we     = 1'b0;
        addr_we    = 1'b0;
        wr_idx     = r_idx;
        key_wdata  = rkey;
        addr_wdata = raddr;
        case (i_cmd.wr_op)
            sbnt_pkg::WR_SHIFT: begin
                key_we  = 1'b1;
                addr_we = 1'b1;
            end
            sbnt_pkg::WR_NEW: begin
                key_we     = 1'b1;
                addr_we    = 1'b1;
                wr_idx     = r_pos;
                key_wdata  = r_key;
                addr_wdata = r_addr;
            end
            sbnt_pkg::WR_UPD: begin
                key_we    = 1'b1;
                key_wdata = r_key;
            end
            default: begin
            end
        endcase
    end

    sbnt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(wr_idx[AW-1:0]), .i_wdata(key_wdata),
        .i_raddr(rd_idx[AW-1:0]), .o_rdata(rkey)
    );

    sbnt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_addrs (
        .i_clk(i_clk), .i_we(addr_we), .i_waddr(wr_idx[AW-1:0]), .i_wdata(addr_wdata),
        .i_raddr(rd_idx[AW-1:0]), .o_rdata(raddr)
    );

    always_comb begin
        case (i_cmd.idx_op)
            sbnt_pkg::IDX_ZERO:  n_idx = '0;
            sbnt_pkg::IDX_COUNT: n_idx = r_count;
            sbnt_pkg::IDX_HALF:  n_idx = r_count >> 1;
            sbnt_pkg::IDX_INC:   n_idx = r_idx + CW'(1);
            sbnt_pkg::IDX_DEC:   n_idx = r_idx - CW'(1);
            default:             n_idx = r_idx;
        endcase
        case (i_cmd.pos_op)
            sbnt_pkg::POS_IDX:  n_pos = r_idx;
            sbnt_pkg::POS_MID:  n_pos = r_mid;
            sbnt_pkg::POS_ZERO: n_pos = '0;
            default:            n_pos = r_pos;
        endcase
        case (i_cmd.cnt_op)
            sbnt_pkg::CNT_INC:  n_count = r_count + CW'(1);
            sbnt_pkg::CNT_HALF: n_count = r_count >> 1;
            default:            n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= sbnt_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_pos <= n_pos;
        if (i_cmd.load_in) begin
            r_kind <= i_in_beat.kind;
            r_key  <= KEY_WIDTH'(64'(i_in_beat.key_value));
            r_addr <= i_in_beat.child_addr;
        end
        if (i_cmd.cnt_op == sbnt_pkg::CNT_HALF) begin
            r_end <= r_count;
        end
        if (i_cmd.mid_load) begin
            r_mid <= mid_c;
        end
        case (i_cmd.bs_op)
            sbnt_pkg::BS_INIT: begin
                r_first <= '0;
                r_last  <= SW'({1'b0, r_count}) - SW'(1);
            end
            sbnt_pkg::BS_LO: r_first <= SW'({1'b0, r_mid}) + SW'(1);
            sbnt_pkg::BS_HI: r_last  <= SW'({1'b0, r_mid}) - SW'(1);
            default: begin
            end
        endcase
        case (i_cmd.res_op)
            sbnt_pkg::RES_NEW: begin
                r_res_key  <= r_key;
                r_res_addr <= r_addr;
                r_res_chg  <= (r_pos == '0);
            end
            sbnt_pkg::RES_RD: begin
                r_res_key  <= rkey;
                r_res_addr <= raddr;
                r_res_chg  <= 1'b0;
            end
            sbnt_pkg::RES_UPD: begin
                r_res_key  <= r_key;
                r_res_addr <= raddr;
                r_res_chg  <= (r_idx == '0);
            end
            default: begin
            end
        endcase
        if (i_cmd.stat_load) begin
            r_status <= i_cmd.stat;
        end
        if (i_cmd.out_load) begin
            r_out.status      <= r_status;
            r_out.entry_count <= 6'(r_count);
            r_out.last        <= i_cmd.out_last;
            if (r_status == sbnt_pkg::ST_OK) begin
                r_out.out_key       <= 32'(64'(r_res_key));
                r_out.out_addr      <= r_res_addr;
                r_out.out_index     <= 6'(r_pos);
                r_out.first_changed <= r_res_chg;
            end else begin
                r_out.out_key       <= '0;
                r_out.out_addr      <= '0;
                r_out.out_index     <= '0;
                r_out.first_changed <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.kind         = r_kind;
        o_sts.full         = (8'(r_count) >= lim);
        o_sts.empty        = (r_count == '0);
        o_sts.too_few      = (r_count < CW'(2));
        o_sts.idx_eq_count = (r_idx == r_count);
        o_sts.idx_eq_pos   = (r_idx == r_pos);
        o_sts.key_gt       = (rkey > r_key);
        o_sts.key_lt       = (rkey < r_key);
        o_sts.addr_eq      = (raddr == r_addr);
        o_sts.bs_done      = (r_first > r_last);
        o_sts.mid_is_last  = (r_mid == r_count - CW'(1));
        o_sts.split_last   = (CW'(r_idx + CW'(1)) == r_end);
        o_sts.out_free     = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;
endmodule
`default_nettype wire

// ----- src/sbnt_ctrl.sv -----
// Controller: sequences each operation over the entry memories.
`default_nettype none
module sbnt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output      logic            o_in_stall,
    input  wire sbnt_pkg::t_sts  i_sts,
    output      sbnt_pkg::t_cmd  o_cmd
);
    sbnt_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbnt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != sbnt_pkg::S_IDLE);
        unique case (r_state)
            sbnt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = sbnt_pkg::S_DISPATCH;
                end
            end
            sbnt_pkg::S_DISPATCH: begin
                o_cmd.stat_load = 1'b1;
                o_cmd.stat      = sbnt_pkg::ST_OK;
                unique case (i_sts.kind) inside
                    sbnt_pkg::KIND_INSERT: begin
                        if (i_sts.full) begin
                            o_cmd.stat = sbnt_pkg::ST_FULL;
                            n_state = sbnt_pkg::S_EMIT;
                        end else begin
                            o_cmd.idx_op = sbnt_pkg::IDX_ZERO;
                            n_state = sbnt_pkg::S_INS_SCAN;
                        end
                    end
                    sbnt_pkg::KIND_KSEARCH: begin
                        if (i_sts.empty) begin
                            o_cmd.stat = sbnt_pkg::ST_EMPTY;
                            n_state = sbnt_pkg::S_EMIT;
                        end else begin
                            o_cmd.rd_src = sbnt_pkg::RD_ZERO;
                            n_state = sbnt_pkg::S_KS_CHK0;
                        end
                    end
                    sbnt_pkg::KIND_ASEARCH, sbnt_pkg::KIND_UPDATE: begin
                        o_cmd.idx_op = sbnt_pkg::IDX_ZERO;
                        n_state = sbnt_pkg::S_AS_SCAN;
                    end
                    sbnt_pkg::KIND_SPLIT: begin
                        if (i_sts.too_few) begin
                            o_cmd.stat = sbnt_pkg::ST_TOOFEW;
                            n_state = sbnt_pkg::S_EMIT;
                        end else begin
                            o_cmd.idx_op = sbnt_pkg::IDX_HALF;
                            o_cmd.cnt_op = sbnt_pkg::CNT_HALF;
                            n_state = sbnt_pkg::S_SP_RD;
                        end
                    end
                    default: n_state = sbnt_pkg::S_IDLE;
                endcase
            end
            sbnt_pkg::S_INS_SCAN: begin
                if (i_sts.idx_eq_count) begin
                    o_cmd.pos_op = sbnt_pkg::POS_IDX;
                    n_state = sbnt_pkg::S_INS_SHIFT;
                end else begin
                    o_cmd.rd_src = sbnt_pkg::RD_IDX;
                    n_state = sbnt_pkg::S_INS_CHK;
                end
            end
            sbnt_pkg::S_INS_CHK: begin
                if (i_sts.key_gt) begin
                    o_cmd.pos_op = sbnt_pkg::POS_IDX;
                    o_cmd.idx_op = sbnt_pkg::IDX_COUNT;
                    n_state = sbnt_pkg::S_INS_SHIFT;
                end else begin
                    o_cmd.idx_op = sbnt_pkg::IDX_INC;
                    n_state = sbnt_pkg::S_INS_SCAN;
                end
            end
            sbnt_pkg::S_INS_SHIFT: begin
                if (i_sts.idx_eq_pos) begin
                    n_state = sbnt_pkg::S_INS_WRITE;
                end else begin
                    o_cmd.rd_src = sbnt_pkg::RD_IDXM1;
                    n_state = sbnt_pkg::S_INS_SHWR;
                end
            end
            sbnt_pkg::S_INS_SHWR: begin
                o_cmd.wr_op  = sbnt_pkg::WR_SHIFT;
                o_cmd.idx_op = sbnt_pkg::IDX_DEC;
                n_state = sbnt_pkg::S_INS_SHIFT;
            end
            sbnt_pkg::S_INS_WRITE: begin
                o_cmd.wr_op  = sbnt_pkg::WR_NEW;
                o_cmd.cnt_op = sbnt_pkg::CNT_INC;
                o_cmd.res_op = sbnt_pkg::RES_NEW;
                n_state = sbnt_pkg::S_EMIT;
            end
            sbnt_pkg::S_KS_CHK0: begin
                if (i_sts.key_gt) begin
                    o_cmd.pos_op = sbnt_pkg::POS_ZERO;
                    n_state = sbnt_pkg::S_KS_FETCH;
                end else begin
                    o_cmd.bs_op = sbnt_pkg::BS_INIT;
                    n_state = sbnt_pkg::S_KS_LOOP;
                end
            end
            sbnt_pkg::S_KS_LOOP: begin
                if (i_sts.bs_done) begin
                    o_cmd.pos_op = sbnt_pkg::POS_ZERO;
                    n_state = sbnt_pkg::S_KS_FETCH;
                end else begin
                    o_cmd.rd_src   = sbnt_pkg::RD_MID;
                    o_cmd.mid_load = 1'b1;
                    n_state = sbnt_pkg::S_KS_CMP;
                end
            end
            sbnt_pkg::S_KS_CMP: begin
                if (i_sts.key_lt) begin
                    if (i_sts.mid_is_last) begin
                        o_cmd.pos_op = sbnt_pkg::POS_MID;
                        n_state = sbnt_pkg::S_KS_FETCH;
                    end else begin
                        o_cmd.rd_src = sbnt_pkg::RD_MIDP1;
                        n_state = sbnt_pkg::S_KS_CMP2;
                    end
                end else if (i_sts.key_gt) begin
                    o_cmd.bs_op = sbnt_pkg::BS_HI;
                    n_state = sbnt_pkg::S_KS_LOOP;
                end else begin
                    o_cmd.pos_op = sbnt_pkg::POS_MID;
                    n_state = sbnt_pkg::S_KS_FETCH;
                end
            end
            sbnt_pkg::S_KS_CMP2: begin
                if (i_sts.key_gt) begin
                    o_cmd.pos_op = sbnt_pkg::POS_MID;
                    n_state = sbnt_pkg::S_KS_FETCH;
                end else begin
                    o_cmd.bs_op = sbnt_pkg::BS_LO;
                    n_state = sbnt_pkg::S_KS_LOOP;
                end
            end
            sbnt_pkg::S_KS_FETCH: begin
                o_cmd.rd_src = sbnt_pkg::RD_POS;
                n_state = sbnt_pkg::S_KS_GOT;
            end
            sbnt_pkg::S_KS_GOT: begin
                o_cmd.res_op = sbnt_pkg::RES_RD;
                n_state = sbnt_pkg::S_EMIT;
            end
            sbnt_pkg::S_AS_SCAN: begin
                if (i_sts.idx_eq_count) begin
                    o_cmd.stat_load = 1'b1;
                    o_cmd.stat      = sbnt_pkg::ST_NOTFOUND;
                    n_state = sbnt_pkg::S_EMIT;
                end else begin
                    o_cmd.rd_src = sbnt_pkg::RD_IDX;
                    n_state = sbnt_pkg::S_AS_CHK;
                end
            end
            sbnt_pkg::S_AS_CHK: begin
                if (i_sts.addr_eq) begin
                    o_cmd.pos_op = sbnt_pkg::POS_IDX;
                    if (i_sts.kind == sbnt_pkg::KIND_UPDATE) begin
                        o_cmd.wr_op  = sbnt_pkg::WR_UPD;
                        o_cmd.res_op = sbnt_pkg::RES_UPD;
                    end else begin
                        o_cmd.res_op = sbnt_pkg::RES_RD;
                    end
                    n_state = sbnt_pkg::S_EMIT;
                end else begin
                    o_cmd.idx_op = sbnt_pkg::IDX_INC;
                    n_state = sbnt_pkg::S_AS_SCAN;
                end
            end
            sbnt_pkg::S_SP_RD: begin
                o_cmd.rd_src = sbnt_pkg::RD_IDX;
                n_state = sbnt_pkg::S_SP_GOT;
            end
            sbnt_pkg::S_SP_GOT: begin
                o_cmd.res_op = sbnt_pkg::RES_RD;
                o_cmd.pos_op = sbnt_pkg::POS_IDX;
                n_state = sbnt_pkg::S_SP_EMIT;
            end
            sbnt_pkg::S_SP_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = i_sts.split_last;
                    if (i_sts.split_last) begin
                        n_state = sbnt_pkg::S_IDLE;
                    end else begin
                        o_cmd.idx_op = sbnt_pkg::IDX_INC;
                        n_state = sbnt_pkg::S_SP_RD;
                    end
                end
            end
            sbnt_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state = sbnt_pkg::S_IDLE;
                end
            end
            default: n_state = sbnt_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
